// ----- src/ddf_pkg.sv -----
// ddf_pkg: widths, codes, record types and register reset values shared by
// the upwind face flux block; no dependencies
package ddf_pkg;

	// fixed point format and field widths
	localparam int FRAC_BITS = 16;
	localparam int P_W       = 32;
	localparam int S_W       = 17;
	localparam int K_W       = 31;
	localparam int EPS_W     = 16;
	localparam int OUT_W     = 32;
	localparam int CFG_W     = 31;

	// derived arithmetic widths
	localparam int DP_W     = P_W + 1;
	localparam int REL_W    = 2 * S_W - FRAC_BITS;
	localparam int KB_W     = K_W + 1;
	localparam int NH_W     = 2 * K_W + 1;
	localparam int DEN_W    = K_W + 2;
	localparam int KPROD_W  = KB_W + REL_W;
	localparam int MOB_W    = KPROD_W;
	localparam int GRAD_W   = DP_W + K_W - FRAC_BITS;
	localparam int SPLIT_W  = 25;
	localparam int PROD_W   = MOB_W + GRAD_W;
	localparam int FPROD_W  = K_W + OUT_W;
	localparam int FMAG_W   = FPROD_W - FRAC_BITS;

	// saturation bounds as magnitudes
	localparam logic [OUT_W-1:0] NEG_BOUND = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [OUT_W-1:0] POS_BOUND = {1'b0, {(OUT_W-1){1'b1}}};

	// register indexes
	localparam logic [1:0] REG_INV_X = 2'd0;
	localparam logic [1:0] REG_INV_Y = 2'd1;
	localparam logic [1:0] REG_MODE  = 2'd2;
	localparam logic [1:0] REG_EPS   = 2'd3;

	typedef enum logic [1:0] {
		MODE_ARITH,
		MODE_LEFT,
		MODE_RIGHT,
		MODE_HARM
	} ddf_mode_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_SAT,
		ST_MU_ZERO
	} ddf_status_t;

	// register reset values
	localparam logic [K_W-1:0]   INV_RESET = K_W'(65536);
	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

	typedef struct packed {
		logic [K_W-1:0]   inv_x;
		logic [K_W-1:0]   inv_y;
		ddf_mode_t        mode;
		logic [EPS_W-1:0] eps;
	} ddf_cfg_t;

	// one classified face as it sits in the queue
	typedef struct packed {
		logic [REL_W-1:0]  rel;
		logic [NH_W-1:0]   nh;
		logic [DEN_W-1:0]  den;
		logic [KB_W-1:0]   ksel;
		logic              harm;
		logic              den0;
		logic [GRAD_W-1:0] grad;
		logic [K_W-1:0]    mu;
		logic [K_W-1:0]    rhox;
		logic              neg;
		logic              mu_zero;
	} ddf_face_t;

	// side data riding with the harmonic divider
	typedef struct packed {
		logic [REL_W-1:0]  rel;
		logic [KB_W-1:0]   ksel;
		logic              harm;
		logic              den0;
		logic [GRAD_W-1:0] grad;
		logic [K_W-1:0]    mu;
		logic [K_W-1:0]    rhox;
		logic              neg;
		logic              mu_zero;
	} ddf_htag_t;

	// side data riding with the mobility divider
	typedef struct packed {
		logic [GRAD_W-1:0] grad;
		logic [K_W-1:0]    rhox;
		logic              neg;
		logic              mu_zero;
	} ddf_mtag_t;

endpackage

// ----- src/ddf_div.sv -----
// ddf_div: pipelined restoring divider, one quotient bit per stage, with a
// side-data tag carried alongside; no package dependency
module ddf_div #(
	parameter int N_W   = 32,
	parameter int D_W   = 33,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [D_W-1:0]   rem_in,
	input  logic [N_W-1:0]   num_in,
	input  logic [D_W-1:0]   den_in,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_valid,
	output logic [N_W-1:0]   quo,
	output logic [TAG_W-1:0] tag_out
);

	logic [D_W-1:0]   rem_s [1:N_W-1];
	logic [D_W-1:0]   den_s [1:N_W-1];
	logic [N_W-1:0]   num_s [1:N_W];
	logic [TAG_W-1:0] tag_s [1:N_W];
	logic [N_W:1]     vld_s;

	logic [D_W-1:0]   rem_w  [0:N_W-1];
	logic [D_W-1:0]   den_w  [0:N_W-1];
	logic [N_W-1:0]   num_w  [0:N_W-1];
	logic [N_W-1:0]   num_nx [0:N_W-1];
	logic [D_W-1:0]   rem_nx [0:N_W-2];

	// one trial subtract per stage; the numerator register fills with quotient bits
	for (genvar i = 0; i < N_W; i++) begin : g_st
		logic [D_W:0] trial;
		logic         ge;
		if (i == 0) begin : g_first
			assign rem_w[i] = rem_in;
			assign den_w[i] = den_in;
			assign num_w[i] = num_in;
		end else begin : g_rest
			assign rem_w[i] = rem_s[i];
			assign den_w[i] = den_s[i];
			assign num_w[i] = num_s[i];
		end
		assign trial     = {rem_w[i], num_w[i][N_W-1]};
		assign ge        = trial >= {1'b0, den_w[i]};
		assign num_nx[i] = {num_w[i][N_W-2:0], ge};
		if (i < N_W - 1) begin : g_rem
			assign rem_nx[i] = ge ? D_W'(trial - {1'b0, den_w[i]}) : trial[D_W-1:0];
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N_W-1:1], in_valid};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[1] <= tag_in;
			den_s[1] <= den_in;
			for (int k = 0; k < N_W; k++) begin
				num_s[k+1] <= num_nx[k];
			end
			for (int k = 1; k < N_W; k++) begin
				tag_s[k+1] <= tag_s[k];
				rem_s[k]   <= rem_nx[k-1];
			end
			for (int k = 1; k < N_W - 1; k++) begin
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign out_valid = vld_s[N_W];
	assign quo       = num_s[N_W];
	assign tag_out   = tag_s[N_W];

endmodule

// ----- src/ddf_front.sv -----
// ddf_front: accepts face beats, picks the upwind side and forms the
// products that need no division; depends on ddf_pkg
module ddf_front
	import ddf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  ddf_cfg_t            cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [P_W-1:0] pressure_left,
	input  logic signed [P_W-1:0] pressure_right,
	input  logic [S_W-1:0]      saturation_left,
	input  logic [S_W-1:0]      saturation_right,
	input  logic [K_W-1:0]      perm_left,
	input  logic [K_W-1:0]      perm_right,
	input  logic [K_W-1:0]      visc_left,
	input  logic [K_W-1:0]      visc_right,
	input  logic [K_W-1:0]      rhox_left,
	input  logic [K_W-1:0]      rhox_right,
	input  logic                axis,
	output logic                push_valid,
	input  logic                push_ready,
	output ddf_face_t           face
);

	logic            vld_s1, vld_s2;
	logic [S_W-1:0]  s_s1;
	logic [K_W-1:0]  kl_s1, kr_s1, mu_s1, rhox_s1, invh_s1;
	logic [DP_W-1:0] dp_s1;
	logic            neg_s1;
	ddf_face_t       face_s2;

	logic            adv_s1, adv_s2;
	logic            left_w, neg_w;
	logic [DP_W-1:0] diff_w;

	assign adv_s2   = !vld_s2 || push_ready;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;

	// upwind side: left wins only when its pressure is strictly higher
	assign left_w = pressure_left > pressure_right;
	assign neg_w  = pressure_right > pressure_left;
	assign diff_w = DP_W'({pressure_right[P_W-1], pressure_right})
		- DP_W'({pressure_left[P_W-1], pressure_left});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	// stage 1: selection and pressure difference magnitude
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			s_s1    <= left_w ? saturation_left : saturation_right;
			mu_s1   <= left_w ? visc_left : visc_right;
			rhox_s1 <= left_w ? rhox_left : rhox_right;
			kl_s1   <= perm_left;
			kr_s1   <= perm_right;
			invh_s1 <= axis ? cfg.inv_y : cfg.inv_x;
			dp_s1   <= neg_w ? diff_w : DP_W'(-diff_w);
			neg_s1  <= neg_w;
		end
	end

	// stage 2: squares, products and the simple blends
	logic [2*S_W-1:0]       sq_w;
	logic [2*K_W-1:0]       kk_w;
	logic [DP_W+K_W-1:0]    gp_w;
	logic [K_W:0]           ksum_w;
	logic [DEN_W-1:0]       den_w;
	logic [KB_W-1:0]        ksel_w;

	assign sq_w   = s_s1 * s_s1;
	assign kk_w   = kl_s1 * kr_s1;
	assign gp_w   = dp_s1 * invh_s1;
	assign ksum_w = {1'b0, kl_s1} + {1'b0, kr_s1};
	assign den_w  = DEN_W'(ksum_w) + DEN_W'(cfg.eps);

	always_comb begin
		unique case (cfg.mode)
			MODE_ARITH: ksel_w = KB_W'(ksum_w[K_W:1]);
			MODE_LEFT:  ksel_w = KB_W'(kl_s1);
			MODE_RIGHT: ksel_w = KB_W'(kr_s1);
			default:    ksel_w = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			face_s2.rel     <= sq_w[2*S_W-1:FRAC_BITS];
			face_s2.nh      <= {kk_w, 1'b0};
			face_s2.den     <= den_w;
			face_s2.ksel    <= ksel_w;
			face_s2.harm    <= cfg.mode == MODE_HARM;
			face_s2.den0    <= den_w == '0;
			face_s2.grad    <= gp_w[DP_W+K_W-1:FRAC_BITS];
			face_s2.mu      <= mu_s1;
			face_s2.rhox    <= rhox_s1;
			face_s2.neg     <= neg_s1;
			face_s2.mu_zero <= mu_s1 == '0;
		end
	end

	assign push_valid = vld_s2;
	assign face       = face_s2;

endmodule

// ----- src/ddf_queue.sv -----
// ddf_queue: short register queue between front and back so either side
// can stall alone; depends on ddf_pkg
module ddf_queue
	import ddf_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  ddf_face_t push_face,
	output logic      pop_valid,
	input  logic      pop,
	output ddf_face_t pop_face
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ddf_face_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_face   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_face;
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");
`endif

endmodule

// ----- src/ddf_back.sv -----
// ddf_back: harmonic blend, mobility division, velocity and flux with
// saturation, output register; depends on ddf_pkg and ddf_div
module ddf_back
	import ddf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	input  ddf_face_t             pop_face,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [OUT_W-1:0] phase_velocity,
	output logic signed [OUT_W-1:0] flux_term,
	output logic [1:0]            status
);

	localparam int LL_W  = 2 * SPLIT_W;
	localparam int LH_W  = GRAD_W;
	localparam int HL_W  = MOB_W;
	localparam int HH_W  = MOB_W - SPLIT_W + GRAD_W - SPLIT_W;
	localparam int MID_W = HL_W + 1;
	localparam int HTAG_W = $bits(ddf_htag_t);
	localparam int MTAG_W = $bits(ddf_mtag_t);

	logic adv;
	assign adv = !out_valid || out_ready;
	assign pop = adv && pop_valid;

	// stage 3: queue head
	logic      vld_s3;
	ddf_face_t face_s3;
	ddf_htag_t htag_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= pop_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) face_s3 <= pop_face;
	end

	assign htag_in = '{rel: face_s3.rel, ksel: face_s3.ksel, harm: face_s3.harm,
		den0: face_s3.den0, grad: face_s3.grad, mu: face_s3.mu, rhox: face_s3.rhox,
		neg: face_s3.neg, mu_zero: face_s3.mu_zero};

	// harmonic mean 2*kL*kR / (kL+kR+eps); the quotient fits the blend width
	logic              hvld;
	logic [KB_W-1:0]   hq;
	logic [HTAG_W-1:0] htag_raw;
	ddf_htag_t         htag;

	ddf_div #(.N_W(KB_W), .D_W(DEN_W), .TAG_W(HTAG_W)) u_hdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s3),
		.rem_in    (DEN_W'(face_s3.nh[NH_W-1:KB_W])),
		.num_in    (face_s3.nh[KB_W-1:0]),
		.den_in    (face_s3.den),
		.tag_in    (HTAG_W'(htag_in)),
		.out_valid (hvld),
		.quo       (hq),
		.tag_out   (htag_raw)
	);
	assign htag = ddf_htag_t'(htag_raw);

	// stage 4: blended permeability times relative permeability
	logic              vld_s4;
	logic [KPROD_W-1:0] kprod_s4;
	ddf_mtag_t         mtag_s4;
	logic [K_W-1:0]    mu_s4;
	logic [KB_W-1:0]   k_w;

	assign k_w = htag.harm ? (htag.den0 ? '0 : hq) : htag.ksel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= hvld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kprod_s4 <= k_w * htag.rel;
			mu_s4    <= htag.mu;
			mtag_s4  <= '{grad: htag.grad, rhox: htag.rhox, neg: htag.neg,
				mu_zero: htag.mu_zero};
		end
	end

	// mobility: truncated product divided by upwind viscosity
	logic              mvld;
	logic [MOB_W-1:0]  mq;
	logic [MTAG_W-1:0] mtag_raw;
	ddf_mtag_t         mtag;

	ddf_div #(.N_W(MOB_W), .D_W(K_W), .TAG_W(MTAG_W)) u_mdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s4),
		.rem_in    ('0),
		.num_in    ({kprod_s4[KPROD_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}}),
		.den_in    (mu_s4),
		.tag_in    (MTAG_W'(mtag_s4)),
		.out_valid (mvld),
		.quo       (mq),
		.tag_out   (mtag_raw)
	);
	assign mtag = ddf_mtag_t'(mtag_raw);

	// stages 5 to 7: mobility times gradient as four partial products
	logic              vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic [LL_W-1:0]   ll_s5, ll_s6;
	logic [LH_W-1:0]   lh_s5;
	logic [HL_W-1:0]   hl_s5;
	logic [HH_W-1:0]   hh_s5, hh_s6;
	logic [MID_W-1:0]  mid_s6;
	logic [PROD_W-1:0] p_s7;
	logic [K_W-1:0]    rhox_s5, rhox_s6, rhox_s7, rhox_s8;
	logic              neg_s5, neg_s6, neg_s7;
	logic              mz_s5, mz_s6, mz_s7, mz_s8, mz_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= mvld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ll_s5   <= mq[SPLIT_W-1:0] * mtag.grad[SPLIT_W-1:0];
			lh_s5   <= mq[SPLIT_W-1:0] * mtag.grad[GRAD_W-1:SPLIT_W];
			hl_s5   <= mq[MOB_W-1:SPLIT_W] * mtag.grad[SPLIT_W-1:0];
			hh_s5   <= mq[MOB_W-1:SPLIT_W] * mtag.grad[GRAD_W-1:SPLIT_W];
			rhox_s5 <= mtag.rhox;
			neg_s5  <= mtag.neg;
			mz_s5   <= mtag.mu_zero;

			mid_s6  <= MID_W'(lh_s5) + MID_W'(hl_s5);
			ll_s6   <= ll_s5;
			hh_s6   <= hh_s5;
			rhox_s6 <= rhox_s5;
			neg_s6  <= neg_s5;
			mz_s6   <= mz_s5;

			p_s7    <= (PROD_W'(hh_s6) << (2 * SPLIT_W)) + (PROD_W'(mid_s6) << SPLIT_W)
				+ PROD_W'(ll_s6);
			rhox_s7 <= rhox_s6;
			neg_s7  <= neg_s6;
			mz_s7   <= mz_s6;
		end
	end

	// stage 8: velocity magnitude, sign and clamp
	logic             hi_w, nz_w, nege_w, satv_w;
	logic [OUT_W-1:0] v32_w, vc_w;
	logic [OUT_W-1:0] vc_s8, vel_s8, vel_s9;
	logic             nege_s8, satv_s8, nege_s9, satv_s9;

	assign hi_w   = |p_s7[PROD_W-1:OUT_W+FRAC_BITS];
	assign v32_w  = p_s7[OUT_W+FRAC_BITS-1:FRAC_BITS];
	assign nz_w   = hi_w || (v32_w != '0);
	assign nege_w = neg_s7 && nz_w;
	assign satv_w = nege_w ? (hi_w || (v32_w > NEG_BOUND)) : (hi_w || v32_w[OUT_W-1]);
	assign vc_w   = satv_w ? (nege_w ? NEG_BOUND : POS_BOUND) : v32_w;

	always_ff @(posedge clk) begin
		if (adv) begin
			vc_s8   <= vc_w;
			vel_s8  <= nege_w ? OUT_W'(-vc_w) : vc_w;
			nege_s8 <= nege_w;
			satv_s8 <= satv_w;
			rhox_s8 <= rhox_s7;
			mz_s8   <= mz_s7;
		end
	end

	// stage 9: flux product on the clamped velocity
	logic [FPROD_W-1:0] fprod_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			fprod_s9 <= rhox_s8 * vc_s8;
			vel_s9   <= vel_s8;
			nege_s9  <= nege_s8;
			satv_s9  <= satv_s8;
			mz_s9    <= mz_s8;
		end
	end

	// stage 10: flux clamp, status and output register
	logic [FMAG_W-1:0] fmag_w;
	logic              negf_w, satf_w;
	logic [OUT_W-1:0]  fv_w;
	logic              vld_s10;
	logic [OUT_W-1:0]  vel_s10, flux_s10;
	ddf_status_t       st_s10;

	assign fmag_w = fprod_s9[FPROD_W-1:FRAC_BITS];
	assign negf_w = nege_s9 && (fmag_w != '0);
	assign satf_w = negf_w ? (fmag_w > FMAG_W'(NEG_BOUND)) : (fmag_w > FMAG_W'(POS_BOUND));
	assign fv_w   = satf_w ? (negf_w ? NEG_BOUND : POS_BOUND) : fmag_w[OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s10 <= 1'b0;
		else if (adv) vld_s10 <= vld_s9;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (mz_s9) begin
				vel_s10  <= '0;
				flux_s10 <= '0;
				st_s10   <= ST_MU_ZERO;
			end else begin
				vel_s10  <= vel_s9;
				flux_s10 <= negf_w ? OUT_W'(-fv_w) : fv_w;
				st_s10   <= (satv_s9 || satf_w) ? ST_SAT : ST_OK;
			end
		end
	end

	assign out_valid      = vld_s10;
	assign phase_velocity = vel_s10;
	assign flux_term      = flux_s10;
	assign status         = st_s10;

endmodule

// ----- src/darcy_upwind_face_flux_top.sv -----
// darcy_upwind_face_flux_top: configuration registers and the front, queue
// and back of the face flux pipeline; depends on ddf_pkg and all ddf modules
//
//  channel | signals                          | beat taken when
//  --------+----------------------------------+--------------------------
//  in      | in_valid/in_ready, face fields   | in_valid && in_ready
//  out     | out_valid/out_ready, results     | out_valid && out_ready
//  cfg     | cfg_we, cfg_index, cfg_data      | cfg_we
//
// one face per cycle sustained while out_ready stays high; a face passes the front
// stages, the queue, the queue head stage, the 32 harmonic divider stages, the
// product stage, the 50 mobility divider stages and the multiply, clamp and output
// stages. the two bit-per-stage dividers set the latency. a stalled output holds the
// back pipeline; the front keeps taking beats until the queue is full.
// reset is asynchronous and clears control state and the registers to defaults.
module darcy_upwind_face_flux_top
	import ddf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [P_W-1:0]   pressure_left,
	input  logic signed [P_W-1:0]   pressure_right,
	input  logic [S_W-1:0]          saturation_left,
	input  logic [S_W-1:0]          saturation_right,
	input  logic [K_W-1:0]          perm_left,
	input  logic [K_W-1:0]          perm_right,
	input  logic [K_W-1:0]          visc_left,
	input  logic [K_W-1:0]          visc_right,
	input  logic [K_W-1:0]          rhox_left,
	input  logic [K_W-1:0]          rhox_right,
	input  logic                    axis,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] phase_velocity,
	output logic signed [OUT_W-1:0] flux_term,
	output logic [1:0]              status
);

	ddf_cfg_t  cfg_q;
	logic      push_valid, push_ready, pop_valid, pop;
	ddf_face_t push_face, pop_face;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_x <= INV_RESET;
			cfg_q.inv_y <= INV_RESET;
			cfg_q.mode  <= MODE_HARM;
			cfg_q.eps   <= EPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INV_X: cfg_q.inv_x <= cfg_data[K_W-1:0];
				REG_INV_Y: cfg_q.inv_y <= cfg_data[K_W-1:0];
				REG_MODE:  cfg_q.mode  <= ddf_mode_t'(cfg_data[1:0]);
				REG_EPS:   cfg_q.eps   <= cfg_data[EPS_W-1:0];
				default:   ;
			endcase
		end
	end

	ddf_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.pressure_left    (pressure_left),
		.pressure_right   (pressure_right),
		.saturation_left  (saturation_left),
		.saturation_right (saturation_right),
		.perm_left        (perm_left),
		.perm_right       (perm_right),
		.visc_left        (visc_left),
		.visc_right       (visc_right),
		.rhox_left        (rhox_left),
		.rhox_right       (rhox_right),
		.axis             (axis),
		.push_valid       (push_valid),
		.push_ready       (push_ready),
		.face             (push_face)
	);

	ddf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_face  (push_face),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_face   (pop_face)
	);

	ddf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_face       (pop_face),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.phase_velocity (phase_velocity),
		.flux_term      (flux_term),
		.status         (status)
	);

`ifndef SYNTHESIS
	a_mu_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_MU_ZERO |-> phase_velocity == '0 && flux_term == '0)
		else $error("zero viscosity result not cleared");
	a_flux_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase_velocity == '0 |-> flux_term == '0)
		else $error("flux without velocity");
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase_velocity > 0 |-> flux_term >= 0)
		else $error("flux sign differs from velocity");
`endif

endmodule

// ----- sim/darcy_upwind_face_flux_top_tb.sv -----
// darcy_upwind_face_flux_top_tb: self-checking bench for the upwind face flux block,
// with a directed and random face stream, random stalls and register phases
// depends on ddf_pkg and darcy_upwind_face_flux_top
`timescale 1ns / 1ps

module darcy_upwind_face_flux_top_tb;
	import ddf_pkg::*;

	typedef struct {
		logic signed [P_W-1:0] pl, pr;
		logic [S_W-1:0] sl, sr;
		logic [K_W-1:0] kl, kr, ml, mr, rl, rr;
		logic ax;
	} face_t;

	typedef struct {
		logic [OUT_W-1:0] vel;
		logic [OUT_W-1:0] flux;
		ddf_status_t st;
	} flux_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_INV_X;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [P_W-1:0] pressure_left = '0, pressure_right = '0;
	logic [S_W-1:0] saturation_left = '0, saturation_right = '0;
	logic [K_W-1:0] perm_left = '0, perm_right = '0, visc_left = '0, visc_right = '0;
	logic [K_W-1:0] rhox_left = '0, rhox_right = '0;
	logic axis = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] phase_velocity, flux_term;
	logic [1:0] status;

	// shadow copy of the registers
	logic [K_W-1:0] sh_inv_x = INV_RESET, sh_inv_y = INV_RESET;
	ddf_mode_t sh_mode = MODE_HARM;
	logic [EPS_W-1:0] sh_eps = EPS_RESET;

	face_t pending_faces[$];
	flux_res_t expected_flux[$];
	int mismatches = 0;
	int faces_taken = 0;
	bit in_taken = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	bit hold_done = 0;

	darcy_upwind_face_flux_top u_top (.*);

	always #5 clk = ~clk;

	initial begin
		#50ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// signed magnitude clamp to the 32-bit range
	function automatic logic [OUT_W-1:0] clamp_mag(logic [63:0] mag, bit neg, ref bit sat);
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				mag = 64'h8000_0000;
				sat = 1;
			end
			return OUT_W'(64'h1_0000_0000 - mag);
		end
		if (mag > 64'h7FFF_FFFF) begin
			mag = 64'h7FFF_FFFF;
			sat = 1;
		end
		return OUT_W'(mag);
	endfunction

	// expected velocity, flux and status of one face
	function automatic flux_res_t face_flux(face_t f);
		flux_res_t r;
		bit up_left, neg, sat;
		logic [63:0] s, mu, rhox, invh, rel, k, den, mob, dp, grad, vmag, fmag;
		logic [127:0] prod;
		sat = 0;
		up_left = f.pl > f.pr;
		s = up_left ? 64'(f.sl) : 64'(f.sr);
		mu = up_left ? 64'(f.ml) : 64'(f.mr);
		rhox = up_left ? 64'(f.rl) : 64'(f.rr);
		invh = f.ax ? 64'(sh_inv_y) : 64'(sh_inv_x);
		if (mu == 0) begin
			r.vel = '0;
			r.flux = '0;
			r.st = ST_MU_ZERO;
			return r;
		end
		rel = (s * s) >> FRAC_BITS;
		case (sh_mode)
			MODE_ARITH: k = (64'(f.kl) + 64'(f.kr)) >> 1;
			MODE_LEFT: k = 64'(f.kl);
			MODE_RIGHT: k = 64'(f.kr);
			default: begin
				den = 64'(f.kl) + 64'(f.kr) + 64'(sh_eps);
				k = (den == 0) ? 64'd0 : (64'd2 * 64'(f.kl) * 64'(f.kr)) / den;
			end
		endcase
		mob = (((k * rel) >> FRAC_BITS) << FRAC_BITS) / mu;
		neg = f.pr > f.pl;
		dp = neg ? 64'(65'(f.pr) - f.pl) : 64'(65'(f.pl) - f.pr);
		grad = (dp * invh) >> FRAC_BITS;
		prod = 128'(mob) * grad;
		vmag = (prod[127:64] != 0) ? 64'h8000_0001 : prod[63:0] >> FRAC_BITS;
		if (vmag == 0) neg = 0;
		r.vel = clamp_mag(vmag, neg, sat);
		if (neg && vmag > 64'h8000_0000) vmag = 64'h8000_0000;
		else if (!neg && vmag > 64'h7FFF_FFFF) vmag = 64'h7FFF_FFFF;
		fmag = (rhox * vmag) >> FRAC_BITS;
		r.flux = clamp_mag(fmag, neg && fmag != 0, sat);
		r.st = sat ? ST_SAT : ST_OK;
		return r;
	endfunction

	function automatic logic [K_W-1:0] rand_k();
		return K_W'($urandom >> $urandom_range(1, 31));
	endfunction

	// a plausible face: modest spread in magnitudes, rare zero viscosity
	function automatic face_t rand_face();
		face_t f;
		int r;
		r = $urandom_range(0, 9);
		f.pl = (r == 0) ? $urandom : $signed($urandom) >>> $urandom_range(0, 24);
		f.pr = (r == 1) ? f.pl : (r == 2) ? $urandom : $signed($urandom) >>> $urandom_range(0, 24);
		f.sl = ($urandom_range(0, 15) == 0) ? S_W'($urandom) : S_W'($urandom_range(0, 65536));
		f.sr = ($urandom_range(0, 15) == 0) ? S_W'($urandom) : S_W'($urandom_range(0, 65536));
		f.kl = ($urandom_range(0, 19) == 0) ? '0 : rand_k();
		f.kr = ($urandom_range(0, 19) == 0) ? '0 : rand_k();
		f.ml = ($urandom_range(0, 24) == 0) ? '0 : rand_k();
		f.mr = ($urandom_range(0, 24) == 0) ? '0 : rand_k();
		f.rl = rand_k();
		f.rr = rand_k();
		f.ax = 1'($urandom);
		return f;
	endfunction

	function automatic face_t mk(int pl, int pr, int sl, int sr, int k1, int k2,
			int m1, int m2, int r1, int r2, bit ax);
		face_t f;
		f.pl = pl; f.pr = pr; f.sl = S_W'(sl); f.sr = S_W'(sr);
		f.kl = K_W'(k1); f.kr = K_W'(k2);
		f.ml = K_W'(m1); f.mr = K_W'(m2); f.rl = K_W'(r1); f.rr = K_W'(r2); f.ax = ax;
		return f;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_INV_X: sh_inv_x = val;
			REG_INV_Y: sh_inv_y = val;
			REG_MODE: sh_mode = ddf_mode_t'(val[1:0]);
			default: sh_eps = val[EPS_W-1:0];
		endcase
	endtask

	task automatic drain();
		while (pending_faces.size() != 0 || in_valid || expected_flux.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic push_random(int n);
		repeat (n) pending_faces.push_back(rand_face());
	endtask

	// sender: new beat on the falling edge once the previous one is taken
	always @(negedge clk) begin
		face_t f;
		if (arst_n && !(in_valid && !in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_faces.size() != 0) begin
				f = pending_faces.pop_front();
				pressure_left <= f.pl; pressure_right <= f.pr;
				saturation_left <= f.sl; saturation_right <= f.sr;
				perm_left <= f.kl; perm_right <= f.kr;
				visc_left <= f.ml; visc_right <= f.mr;
				rhox_left <= f.rl; rhox_right <= f.rr;
				axis <= f.ax;
				in_valid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off early in the second phase, counted in cycles
	always @(posedge clk) begin
		if (!hold_done && faces_taken >= 100) begin
			hold_done = 1;
			hold_left = 1500;
		end else if (hold_left > 0) begin
			hold_left--;
		end
	end

	// receiver: random stalls, and none taken during the hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			recv_gap = pick_gap();
		end
	end

	// input beats feed the predictor; output beats are checked in order
	always @(posedge clk) begin
		face_t f;
		flux_res_t e;
		in_taken = in_valid && in_ready;
		if (in_taken) begin
			f.pl = pressure_left; f.pr = pressure_right;
			f.sl = saturation_left; f.sr = saturation_right;
			f.kl = perm_left; f.kr = perm_right;
			f.ml = visc_left; f.mr = visc_right;
			f.rl = rhox_left; f.rr = rhox_right;
			f.ax = axis;
			expected_flux.push_back(face_flux(f));
			faces_taken++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_flux.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: vel %h flux %h status %0d",
						phase_velocity, flux_term, status);
			end else begin
				e = expected_flux.pop_front();
				if (phase_velocity !== e.vel || flux_term !== e.flux || status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp vel %h flux %h st %0d, got vel %h flux %h st %0d",
							e.vel, e.flux, e.st, phase_velocity, flux_term, status);
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed faces under reset registers: harmonic, eps 1
		pending_faces.push_back(mk(0, 0, 65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536, 0));
		pending_faces.push_back(mk(32'h7FFFFFFF, 32'h80000000, 131071, 0, 32'h7FFFFFFF,
			32'h7FFFFFFF, 1, 1, 32'h7FFFFFFF, 0, 0));
		pending_faces.push_back(mk(32'h80000000, 32'h7FFFFFFF, 0, 131071, 32'h7FFFFFFF,
			32'h7FFFFFFF, 1, 1, 0, 32'h7FFFFFFF, 1));
		pending_faces.push_back(mk(100, 5, 65536, 65536, 65536, 65536, 0, 65536, 65536, 65536, 0));
		pending_faces.push_back(mk(5, 100, 65536, 65536, 65536, 65536, 65536, 0, 65536, 65536, 1));
		pending_faces.push_back(mk(7, 7, 65536, 0, 65536, 65536, 65536, 0, 65536, 65536, 0));
		pending_faces.push_back(mk(0, 65536, 131071, 131071, 0, 0, 65536, 65536, 65536, 65536, 0));
		pending_faces.push_back(mk(65536, 0, 32768, 32768, 1, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1));
		pending_faces.push_back(mk(0, 1, 65536, 65536, 65536, 65536, 32'h7FFFFFFF,
			32'h7FFFFFFF, 1, 1, 0));
		push_random(80);
		drain();

		// extreme spacing, arithmetic blend, zero epsilon; long run fills the block
		write_reg(REG_INV_X, 31'h7FFFFFFF);
		write_reg(REG_INV_Y, 31'd0);
		write_reg(REG_MODE, CFG_W'(MODE_ARITH));
		write_reg(REG_EPS, 31'd0);
		pending_faces.push_back(mk(-65536, 65536, 65536, 65536, 32'h7FFFFFFF, 32'h7FFFFFFF,
			65536, 65536, 65536, 65536, 0));
		pending_faces.push_back(mk(-65536, 65536, 65536, 65536, 32'h7FFFFFFF, 32'h7FFFFFFF,
			65536, 65536, 65536, 65536, 1));
		push_random(200);
		drain();

		write_reg(REG_MODE, CFG_W'(MODE_LEFT));
		write_reg(REG_INV_Y, 31'd131072);
		push_random(30);
		drain();

		write_reg(REG_MODE, CFG_W'(MODE_RIGHT));
		write_reg(REG_INV_X, 31'd1);
		push_random(30);
		drain();

		// harmonic with zero denominator, then max epsilon
		write_reg(REG_MODE, CFG_W'(MODE_HARM));
		write_reg(REG_INV_X, 31'd65536);
		pending_faces.push_back(mk(0, 65536, 65536, 65536, 0, 0, 65536, 65536, 65536, 65536, 0));
		pending_faces.push_back(mk(65536, 0, 65536, 65536, 0, 0, 65536, 65536, 65536, 65536, 0));
		push_random(30);
		drain();
		write_reg(REG_EPS, 31'h0000FFFF);
		push_random(30);
		drain();

		// random settings for the rest
		repeat (3) begin
			write_reg(REG_INV_X, CFG_W'($urandom >> $urandom_range(1, 20)));
			write_reg(REG_INV_Y, CFG_W'($urandom >> $urandom_range(1, 20)));
			write_reg(REG_MODE, CFG_W'($urandom_range(0, 3)));
			write_reg(REG_EPS, CFG_W'($urandom_range(0, 65535)));
			push_random(20);
			drain();
		end

		if (mismatches == 0 && expected_flux.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
src/ddf_pkg.sv
src/ddf_div.sv
src/ddf_front.sv
src/ddf_queue.sv
src/ddf_back.sv
src/darcy_upwind_face_flux_top.sv
sim/darcy_upwind_face_flux_top_tb.sv
